// ----- rtl/ffdc_pkg.sv -----
// Shared types and constants for the feedforward dynamics compressor.
// Holds the register index codes and the exp2 factor table; no dependencies.
package ffdc_pkg;

  localparam logic [2:0] REG_THRESHOLD_LEVEL = 3'd0;
  localparam logic [2:0] REG_THRESHOLD_LOG2  = 3'd1;
  localparam logic [2:0] REG_GAIN_EXPONENT   = 3'd2;
  localparam logic [2:0] REG_UPWARD_MODE     = 3'd3;
  localparam logic [2:0] REG_ATTACK_COEF     = 3'd4;
  localparam logic [2:0] REG_RELEASE_COEF    = 3'd5;

  localparam int CFG_W = 23;

  typedef logic [15:0][31:0] exp_tab_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] v;
    r = '0;
    b = 64'd1 << 62;
    v = x;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] t;
    t = isqrt64(64'd1 << 61);
    for (int k = 0; k < 16; k++) begin
      tab[k] = t[31:0];
      t = isqrt64(t << 30);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

// ----- rtl/feedforward_dynamics_compressor.sv -----
// Top level of the feedforward peak-envelope dynamics compressor.
// Depends on ffdc_pkg for register codes and the exp2 factor table.
//
//  port group | direction | handshake         | beat payload
//  in_        | input     | in_valid/in_stall | in_channel, in_sample_in
//  out_       | output    | out_valid/out_stall | out_sample_out, out_applied_gain
//  cfg_       | input     | cfg_wr_en         | cfg_index, cfg_wr_data
//
// An item skips the log2 and exp2 steps when the gain is unity, and the exp2 steps
// when the exponent saturates; otherwise 16 log2 squaring steps and 16 exp2
// multiply steps run on one sequencer. Envelopes live in a registered-read memory.
// Reset clears control and config registers and per-channel valid bits, so envelopes read zero.
// A finished result waits in the output register while the next item starts;
// the next result holds in S_OUT until that register drains.
module feedforward_dynamics_compressor
  import ffdc_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [2:0]              in_channel,
  input  logic signed [23:0]      in_sample_in,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [23:0]      out_sample_out,
  output logic [23:0]             out_applied_gain,
  input  logic                    cfg_wr_en,
  input  logic [2:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_wr_data
);

  localparam int IDXW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_READ  = 4'd1;
  localparam logic [3:0] S_ENV1  = 4'd2;
  localparam logic [3:0] S_ENV2  = 4'd3;
  localparam logic [3:0] S_LOGI  = 4'd4;
  localparam logic [3:0] S_LOG   = 4'd5;
  localparam logic [3:0] S_YMUL  = 4'd6;
  localparam logic [3:0] S_EXPI  = 4'd7;
  localparam logic [3:0] S_EXP   = 4'd8;
  localparam logic [3:0] S_SHIFT = 4'd9;
  localparam logic [3:0] S_MUL   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [22:0]        thr_level_r;
  logic signed [21:0] thr_log2_r;
  logic signed [16:0] gain_exp_r;
  logic               upward_r;
  logic [15:0]        atk_r;
  logic [15:0]        rel_r;

  logic [22:0]         env_mem [CHANNELS];
  logic [CHANNELS-1:0] vld_r;
  logic [22:0]         rd_r;
  logic                rdv_r;

  logic [3:0]         state_r;
  logic [3:0]         cnt_r;
  logic [2:0]         ch_r;
  logic               ch_ok_r;
  logic signed [23:0] x_r;
  logic [22:0]        old_r;
  logic [15:0]        c_r;
  logic [39:0]        p1_r;
  logic [22:0]        env_r;
  logic [31:0]        m_r;
  logic [15:0]        frac_r;
  logic [4:0]         pos_r;
  logic signed [24:0] y_r;
  logic signed [6:0]  n_r;
  logic [15:0]        f_r;
  logic [23:0]        gain_r;
  logic signed [49:0] prod_r;
  logic               out_valid_r;
  logic signed [23:0] out_sample_r;
  logic [23:0]        out_gain_r;

  logic [IDXW-1:0]    rd_addr;
  logic [IDXW-1:0]    wr_addr;
  logic               in_ok;
  logic               accept;
  logic               out_free;
  logic [22:0]        rect;
  logic [22:0]        old_v;
  logic [15:0]        c_v;
  logic [39:0]        env_sum;
  logic [22:0]        env_v;
  logic [22:0]        env_nz;
  logic               unity;
  logic [4:0]         pos_v;
  logic [61:0]        sq;
  logic [31:0]        sq_sh;
  logic signed [21:0] l_v;
  logic signed [23:0] diff;
  logic signed [40:0] yprod;
  logic [63:0]        emul;
  logic [6:0]         shamt;
  logic [63:0]        g_v;
  logic signed [33:0] q_v;
  logic signed [23:0] q_sat;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign rd_addr  = IDXW'(in_channel);
  assign wr_addr  = IDXW'(ch_r);
  assign in_ok    = (7'(in_channel) < 7'(CHANNELS));
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    if (x_r[23]) begin
      rect = (x_r == 24'sh800000) ? 23'h7FFFFF : 23'(-x_r);
    end else begin
      rect = x_r[22:0];
    end
    old_v   = (ch_ok_r && rdv_r) ? rd_r : '0;
    c_v     = (rect > old_v) ? atk_r : rel_r;
    env_sum = p1_r + 40'(old_r) * 40'(c_r) + 40'd32768;
    env_v   = env_sum[38:16];
    env_nz  = (env_r == '0) ? 23'd1 : env_r;
    unity   = upward_r ? (env_r > thr_level_r) : (env_r < thr_level_r);
    pos_v   = '0;
    for (int i = 1; i < 23; i++) begin
      if (env_nz[i]) begin
        pos_v = 5'(i);
      end
    end
    sq    = 62'(m_r[30:0]) * 62'(m_r[30:0]);
    sq_sh = sq[61:30];
    l_v   = {6'(7'(pos_r) - 7'd23), frac_r};
    diff  = 24'(l_v) - 24'(thr_log2_r);
    yprod = 41'(gain_exp_r) * 41'(diff);
    emul  = 64'(m_r) * 64'(EXP_TAB[cnt_r]) + 64'd536870912;
    shamt = 7'(7'sd14 - n_r);
    g_v   = (64'(m_r) + (64'd1 << (shamt - 7'd1))) >> shamt;
    q_v   = 34'(prod_r >>> 16);
    if (q_v > 34'sd8388607) begin
      q_sat = 24'sh7FFFFF;
    end else if (q_v < -34'sd8388608) begin
      q_sat = 24'sh800000;
    end else begin
      q_sat = q_v[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r <= env_mem[rd_addr];
    end
    if (state_r == S_ENV2 && ch_ok_r) begin
      env_mem[wr_addr] <= env_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_level_r <= 23'h7FFFFF;
      thr_log2_r  <= '0;
      gain_exp_r  <= '0;
      upward_r    <= 1'b0;
      atk_r       <= '0;
      rel_r       <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_THRESHOLD_LEVEL: thr_level_r <= cfg_wr_data[22:0];
        REG_THRESHOLD_LOG2:  thr_log2_r  <= cfg_wr_data[21:0];
        REG_GAIN_EXPONENT:   gain_exp_r  <= cfg_wr_data[16:0];
        REG_UPWARD_MODE:     upward_r    <= cfg_wr_data[0];
        REG_ATTACK_COEF:     atk_r       <= cfg_wr_data[15:0];
        REG_RELEASE_COEF:    rel_r       <= cfg_wr_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            ch_r    <= in_channel;
            ch_ok_r <= in_ok;
            x_r     <= in_sample_in;
            rdv_r   <= in_ok ? vld_r[rd_addr] : 1'b0;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_ENV1;
        end
        S_ENV1: begin
          old_r   <= old_v;
          c_r     <= c_v;
          p1_r    <= 40'(rect) * (40'd65536 - 40'(c_v));
          state_r <= S_ENV2;
        end
        S_ENV2: begin
          env_r <= env_v;
          if (ch_ok_r) begin
            vld_r[wr_addr] <= 1'b1;
          end
          state_r <= S_LOGI;
        end
        S_LOGI: begin
          if (unity) begin
            gain_r  <= 24'd65536;
            state_r <= S_MUL;
          end else begin
            pos_r   <= pos_v;
            m_r     <= 32'(env_nz) << (5'd30 - pos_v);
            frac_r  <= '0;
            cnt_r   <= '0;
            state_r <= S_LOG;
          end
        end
        S_LOG: begin
          if (sq_sh[31]) begin
            m_r    <= sq_sh >> 1;
            frac_r <= {frac_r[14:0], 1'b1};
          end else begin
            m_r    <= sq_sh;
            frac_r <= {frac_r[14:0], 1'b0};
          end
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) begin
            state_r <= S_YMUL;
          end
        end
        S_YMUL: begin
          y_r     <= 25'(yprod >>> 16);
          state_r <= S_EXPI;
        end
        S_EXPI: begin
          if (y_r >= 25'sd524288) begin
            gain_r  <= 24'hFFFFFF;
            state_r <= S_MUL;
          end else if (y_r < -25'sd2621440) begin
            gain_r  <= '0;
            state_r <= S_MUL;
          end else begin
            n_r     <= 7'(y_r >>> 16);
            f_r     <= y_r[15:0];
            m_r     <= 32'd1073741824;
            cnt_r   <= '0;
            state_r <= S_EXP;
          end
        end
        S_EXP: begin
          if (f_r[4'd15 - cnt_r]) begin
            m_r <= emul[61:30];
          end
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) begin
            state_r <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          gain_r  <= (g_v > 64'hFFFFFF) ? 24'hFFFFFF : g_v[23:0];
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= 50'(signed'({1'b0, gain_r})) * 50'(x_r) + 50'sd32768;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_sample_r <= q_sat;
            out_gain_r   <= gain_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_out   = out_sample_r;
  assign out_applied_gain = out_gain_r;

endmodule
